FILE: rtl/core/avd_pkg.sv
package avd_pkg;

    // field widths
    localparam int ADC_W = 10;
    localparam int LCD_W = 8;
    localparam int MV_W  = 13;
    localparam int POW_W = 14;
    localparam int DIG_W = 4;
    localparam int PROD_W = 24;

    // scaling constants
    localparam logic [MV_W-1:0]  FULL_SCALE_MV = 13'd5000;
    localparam logic [ADC_W-1:0] ADC_MAX_CODE  = 10'd1023;

    // display bytes
    localparam logic [LCD_W-1:0] CMD_LINE_ONE = 8'h80;
    localparam logic [LCD_W-1:0] CMD_LINE_TWO = 8'hC0;
    localparam logic [LCD_W-1:0] CHAR_POINT   = 8'h2E;
    localparam logic [LCD_W-1:0] CHAR_VOLT    = 8'h56;
    localparam logic [LCD_W-1:0] ASCII_ZERO   = 8'h30;

    // position within the seven-byte run
    typedef enum logic [2:0] {
        SLOT_CMD,
        SLOT_THOU,
        SLOT_POINT,
        SLOT_HUN,
        SLOT_TEN,
        SLOT_ONE,
        SLOT_VOLT
    } t_slot;

    // k times the decade weight of a digit slot, k a loop constant
    function automatic logic [POW_W-1:0] dec_multiple(t_slot s, int k);
        logic [POW_W-1:0] m;
        case (s)
            SLOT_THOU: m = POW_W'(k * 1000);
            SLOT_HUN:  m = POW_W'(k * 100);
            SLOT_TEN:  m = POW_W'(k * 10);
            default:   m = POW_W'(k);
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/core/avd_if.sv
interface avd_in_if;
    import avd_pkg::*;

    logic             valid;
    logic             ready;
    logic [ADC_W-1:0] adc_sample;
    logic             channel;

    modport source (output valid, output adc_sample, output channel, input ready);
    modport sink   (input valid, input adc_sample, input channel, output ready);
endinterface

interface avd_out_if;
    import avd_pkg::*;

    logic             valid;
    logic             ready;
    logic [LCD_W-1:0] lcd_byte;
    logic             register_select;
    logic             last;

    modport source (output valid, output lcd_byte, output register_select, output last,
                    input ready);
    modport sink   (input valid, input lcd_byte, input register_select, input last,
                    output ready);
endinterface

FILE: rtl/core/avd_scale.sv
module avd_scale (
    input  logic [avd_pkg::ADC_W-1:0] i_sample,
    output logic [avd_pkg::MV_W-1:0]  o_mv
);
    import avd_pkg::*;

    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] est;
    logic [PROD_W-1:0] back;
    logic [PROD_W-1:0] resid;
    logic [POW_W-1:0]  q0;

    // sample * 5000, then divide by 1023 as x/1024 * (1 + 1/1024 + ...)
    assign prod = PROD_W'(i_sample) * PROD_W'(FULL_SCALE_MV);
    assign est  = prod + (prod >> 10) + (prod >> 20);
    assign q0   = est[PROD_W-1:10];

    // estimate is low by at most one; fix with one compare
    assign back  = {q0, 10'b0} - PROD_W'(q0);
    assign resid = prod - back;
    assign o_mv  = MV_W'(q0 + POW_W'(resid >= PROD_W'(ADC_MAX_CODE)));

endmodule

FILE: rtl/core/avd_digit.sv
module avd_digit (
    input  avd_pkg::t_slot              i_slot,
    input  logic [avd_pkg::MV_W-1:0]    i_rem,
    output logic [avd_pkg::DIG_W-1:0]   o_digit,
    output logic [avd_pkg::MV_W-1:0]    o_rem
);
    import avd_pkg::*;

    logic [POW_W-1:0] taken;

    // parallel compares against k times the decade weight
    always_comb begin
        o_digit = '0;
        taken   = '0;
        for (int k = 1; k <= 9; k++) begin
            if (POW_W'(i_rem) >= dec_multiple(i_slot, k)) begin
                o_digit = DIG_W'(k);
                taken   = dec_multiple(i_slot, k);
            end
        end
        o_rem = i_rem - taken[MV_W-1:0];
    end

endmodule

FILE: rtl/core/adc_to_lcd_voltage_digits_top.sv
// Converter sample to character-display voltage readout.
// Input channel i_in: one beat carries a 10-bit sample and its channel bit.
// Output channel o_out: seven beats per sample, in order the cursor command
// (register_select low), then the characters "d.ddd" and 'V' (register_select
// high); last marks the 'V' beat.
// A sample passes through the input register and the sequencer before its
// first byte reaches the output register; the run then flows one byte per
// cycle while the receiver is ready, one seven-byte run per sample. An input
// register holds the next sample while a run is still going out, so runs
// follow each other back to back. The millivolt value is computed when a
// sample enters the sequencer; one decimal digit is taken off per digit slot.
// Reset clears the input, sequencer and output valid flags; nothing else
// needs clearing. When the receiver stalls, the output register holds its
// beat, the sequencer halts and the input register fills, then input ready
// drops until the sequencer can take the waiting sample.
module adc_to_lcd_voltage_digits_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    avd_in_if.sink        i_in,
    avd_out_if.source     o_out
);
    import avd_pkg::*;

    // input register
    logic             r_in_valid;
    logic [ADC_W-1:0] r_sample;
    logic             r_chan;

    // sequencer
    logic             r_busy;
    t_slot            r_slot;
    t_slot            n_slot;
    logic [MV_W-1:0]  r_rem;
    logic             r_schan;

    // output register
    logic             r_out_valid;
    logic [LCD_W-1:0] r_byte;
    logic             r_rs;
    logic             r_last;
    logic [LCD_W-1:0] n_byte;
    logic             n_rs;
    logic             n_last;

    logic             out_adv;
    logic             seq_step;
    logic             seq_done;
    logic             seq_load;
    logic             is_digit;
    logic [MV_W-1:0]  load_mv;
    logic [MV_W-1:0]  dig_rem;
    logic [DIG_W-1:0] dig;

    avd_scale u_scale (
        .i_sample (r_sample),
        .o_mv     (load_mv)
    );

    avd_digit u_digit (
        .i_slot  (r_slot),
        .i_rem   (r_rem),
        .o_digit (dig),
        .o_rem   (dig_rem)
    );

    // flow control
    assign out_adv  = !r_out_valid || o_out.ready;
    assign seq_step = r_busy && out_adv;
    assign seq_done = seq_step && (r_slot == SLOT_VOLT);
    assign seq_load = r_in_valid && (!r_busy || seq_done);
    assign i_in.ready = !r_in_valid || seq_load;

    assign is_digit = (r_slot == SLOT_THOU) || (r_slot == SLOT_HUN) ||
                      (r_slot == SLOT_TEN) || (r_slot == SLOT_ONE);

    // next slot
    always_comb begin
        case (r_slot)
            SLOT_CMD:   n_slot = SLOT_THOU;
            SLOT_THOU:  n_slot = SLOT_POINT;
            SLOT_POINT: n_slot = SLOT_HUN;
            SLOT_HUN:   n_slot = SLOT_TEN;
            SLOT_TEN:   n_slot = SLOT_ONE;
            SLOT_ONE:   n_slot = SLOT_VOLT;
            default:    n_slot = SLOT_CMD;
        endcase
    end

    // byte for the current slot
    always_comb begin
        n_rs   = 1'b1;
        n_last = 1'b0;
        case (r_slot)
            SLOT_CMD: begin
                n_byte = r_schan ? CMD_LINE_TWO : CMD_LINE_ONE;
                n_rs   = 1'b0;
            end
            SLOT_POINT: begin
                n_byte = CHAR_POINT;
            end
            SLOT_VOLT: begin
                n_byte = CHAR_VOLT;
                n_last = 1'b1;
            end
            default: begin
                n_byte = ASCII_ZERO + LCD_W'(dig);
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_busy      <= 1'b0;
            r_slot      <= SLOT_CMD;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (seq_load) begin
                r_in_valid <= 1'b0;
            end

            if (seq_load) begin
                r_busy <= 1'b1;
                r_slot <= SLOT_CMD;
            end else if (seq_done) begin
                r_busy <= 1'b0;
                r_slot <= SLOT_CMD;
            end else if (seq_step) begin
                r_slot <= n_slot;
            end

            if (seq_step) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_sample <= i_in.adc_sample;
            r_chan   <= i_in.channel;
        end

        if (seq_load) begin
            r_rem   <= load_mv;
            r_schan <= r_chan;
        end else if (seq_step && is_digit) begin
            r_rem <= dig_rem;
        end

        if (seq_step) begin
            r_byte <= n_byte;
            r_rs   <= n_rs;
            r_last <= n_last;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.lcd_byte        = r_byte;
    assign o_out.register_select = r_rs;
    assign o_out.last            = r_last;

endmodule

FILE: bench/avd_readout_checker.sv
module avd_readout_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    avd_in_if    i_in_bus,
    avd_out_if   i_out_bus,
    output int   o_fail_count,
    output int   o_beats_pending,
    output int   o_samples_seen,
    output int   o_beats_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import avd_pkg::*;

    // one display bus beat as the receiver sees it
    typedef struct packed {
        logic [LCD_W-1:0] lcd_byte;
        logic             register_select;
        logic             last;
    } t_display_beat;

    t_display_beat readout_beats_due[$];

    initial begin
        o_fail_count    = 0;
        o_beats_pending = 0;
        o_samples_seen  = 0;
        o_beats_checked = 0;
    end

    // print one line for each mismatch and count it, quiet after the first 30
    task automatic report_mismatch(input string what, input int got, input int want);
        o_fail_count++;
        if (o_fail_count <= 30) begin
            $display("mismatch at beat %0d: %s got %0h want %0h",
                     o_beats_checked, what, got, want);
        end
    endtask

    // scale to millivolts exactly, split into digits, queue the seven bytes
    function automatic void predict_readout(input logic [ADC_W-1:0] sample, input logic chan);
        logic [PROD_W-1:0] product;
        int                millivolts;
        int                digit;
        t_slot             slot;
        t_display_beat     beat;
        product    = PROD_W'(sample) * PROD_W'(FULL_SCALE_MV);
        millivolts = int'(product / PROD_W'(ADC_MAX_CODE));
        for (int k = 0; k < 7; k++) begin
            slot = t_slot'(k);
            beat.register_select = 1'b1;
            beat.last            = 1'b0;
            case (slot)
                SLOT_CMD: begin
                    beat.lcd_byte        = chan ? CMD_LINE_TWO : CMD_LINE_ONE;
                    beat.register_select = 1'b0;
                end
                SLOT_THOU: begin
                    digit         = millivolts / 1000;
                    beat.lcd_byte = ASCII_ZERO + LCD_W'(digit);
                end
                SLOT_POINT: beat.lcd_byte = CHAR_POINT;
                SLOT_HUN: begin
                    digit         = (millivolts / 100) % 10;
                    beat.lcd_byte = ASCII_ZERO + LCD_W'(digit);
                end
                SLOT_TEN: begin
                    digit         = (millivolts / 10) % 10;
                    beat.lcd_byte = ASCII_ZERO + LCD_W'(digit);
                end
                SLOT_ONE: begin
                    digit         = millivolts % 10;
                    beat.lcd_byte = ASCII_ZERO + LCD_W'(digit);
                end
                default: begin
                    beat.lcd_byte = CHAR_VOLT;
                    beat.last     = 1'b1;
                end
            endcase
            readout_beats_due.push_back(beat);
        end
    endfunction

    // watch both channels, predict on input beats, compare output beats in order
    always @(posedge i_clk) begin
        t_display_beat want;
        if (i_rst_n) begin
            if (i_in_bus.valid && i_in_bus.ready) begin
                predict_readout(i_in_bus.adc_sample, i_in_bus.channel);
                o_samples_seen++;
            end
            if (i_out_bus.valid && i_out_bus.ready) begin
                if (readout_beats_due.size() == 0) begin
                    report_mismatch("beat with nothing due, byte", i_out_bus.lcd_byte, 0);
                end else begin
                    want = readout_beats_due.pop_front();
                    if (i_out_bus.lcd_byte !== want.lcd_byte)
                        report_mismatch("lcd_byte", i_out_bus.lcd_byte, want.lcd_byte);
                    if (i_out_bus.register_select !== want.register_select)
                        report_mismatch("register_select", i_out_bus.register_select,
                                        want.register_select);
                    if (i_out_bus.last !== want.last)
                        report_mismatch("last", i_out_bus.last, want.last);
                end
                o_beats_checked++;
            end
            o_beats_pending = readout_beats_due.size();
        end
    end

endmodule

FILE: bench/adc_to_lcd_voltage_digits_top_test.sv
module adc_to_lcd_voltage_digits_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import avd_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   sender_idle;
    int   receiver_idle;
    int   fail_count;
    int   beats_pending;
    int   samples_seen;
    int   beats_checked;

    avd_in_if  in_bus ();
    avd_out_if out_bus ();

    adc_to_lcd_voltage_digits_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    avd_readout_checker readout_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_bus        (in_bus),
        .i_out_bus       (out_bus),
        .o_fail_count    (fail_count),
        .o_beats_pending (beats_pending),
        .o_samples_seen  (samples_seen),
        .o_beats_checked (beats_checked)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver side: random stalls at the falling edge
    initial begin
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_bus.ready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    // one input beat, with random idle cycles ahead of it; entered at a falling edge
    task automatic send_sample(input logic [ADC_W-1:0] sample, input logic chan);
        while ($urandom_range(99) < sender_idle) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.adc_sample <= sample;
        in_bus.channel    <= chan;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // corner samples: zero, full scale, near full scale, digit carries, bit patterns
    logic [ADC_W-1:0] corner_samples [20] = '{
        10'd0, 10'd1, 10'd2, 10'd1023, 10'd1022, 10'd1021, 10'd511, 10'd512,
        10'd205, 10'd204, 10'd409, 10'd614, 10'd818, 10'd1000, 10'h155, 10'h2AA,
        10'h3FF, 10'h200, 10'h100, 10'd3
    };

    // stimulus and verdict
    initial begin
        int phase_idle [3][2];
        int drain_cycles;
        phase_idle        = '{'{32, 83}, '{83, 32}, '{0, 0}};
        in_bus.valid      = 1'b0;
        in_bus.adc_sample = '0;
        in_bus.channel    = 1'b0;
        i_rst_n           = 1'b0;
        sender_idle       = phase_idle[0][0];
        receiver_idle     = phase_idle[0][1];
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners, alternating display line
        foreach (corner_samples[k]) send_sample(corner_samples[k], logic'(k % 2));

        // random samples under each pacing phase
        for (int p = 0; p < 3; p++) begin
            sender_idle   = phase_idle[p][0];
            receiver_idle = phase_idle[p][1];
            repeat (104) send_sample(ADC_W'($urandom_range(1023)), logic'($urandom_range(1)));
        end
        in_bus.valid <= 1'b0;

        // drain, then wait for anything stray
        drain_cycles = 0;
        while (beats_pending != 0 && drain_cycles < 20000) begin
            @(negedge i_clk);
            drain_cycles++;
        end
        repeat (20) @(negedge i_clk);

        $display("covered %0d samples (corners plus random, both lines) and %0d display beats",
                 samples_seen, beats_checked);
        $display("pacing: sender/receiver stalls 32/83, then 83/32, then none");
        if (fail_count == 0 && beats_pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
